>>> src/fpdf_pkg.sv
package fpdf_pkg;

  localparam int MAX_PRECISION = 18;
  localparam int INT_DIGITS    = 20;
  localparam int DIGIT_W       = 4;
  localparam int VALUE_W       = 64;
  localparam int PREC_W        = 5;
  localparam int CHAR_W        = 8;
  localparam int EXP_W         = 11;
  localparam int MANT_W        = 52;
  localparam int FIXED_W       = 2 * VALUE_W;
  localparam int CONV_STEPS    = VALUE_W;
  localparam int CNT_W         = $clog2(CONV_STEPS);
  localparam int IDX_W         = $clog2(INT_DIGITS);
  localparam int FIDX_W        = (MAX_PRECISION > 1) ? $clog2(MAX_PRECISION) : 1;
  localparam int BCD_W         = INT_DIGITS * DIGIT_W;

  localparam logic [EXP_W-1:0] EXP_UNIT = 11'd1075;
  localparam logic [EXP_W-1:0] EXP_SAT  = 11'd1087;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;

  typedef logic [INT_DIGITS-1:0][DIGIT_W-1:0]    int_bcd_t;
  typedef logic [MAX_PRECISION-1:0][DIGIT_W-1:0] frac_bcd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_FRAC,
    ST_ROUND,
    ST_CONV_FRAC,
    ST_CONV_INT,
    ST_COUNT,
    ST_EMIT_INT,
    ST_EMIT_DOT,
    ST_EMIT_FRAC
  } state_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [PREC_W-1:0] p);
    logic [VALUE_W-1:0] v;
    case (p)
      5'd0:    v = 64'd1;
      5'd1:    v = 64'd10;
      5'd2:    v = 64'd100;
      5'd3:    v = 64'd1000;
      5'd4:    v = 64'd10000;
      5'd5:    v = 64'd100000;
      5'd6:    v = 64'd1000000;
      5'd7:    v = 64'd10000000;
      5'd8:    v = 64'd100000000;
      5'd9:    v = 64'd1000000000;
      5'd10:   v = 64'd10000000000;
      5'd11:   v = 64'd100000000000;
      5'd12:   v = 64'd1000000000000;
      5'd13:   v = 64'd10000000000000;
      5'd14:   v = 64'd100000000000000;
      5'd15:   v = 64'd1000000000000000;
      5'd16:   v = 64'd10000000000000000;
      5'd17:   v = 64'd100000000000000000;
      5'd18:   v = 64'd1000000000000000000;
      5'd19:   v = 64'd10000000000000000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic int_bcd_t dabble_adjust(input int_bcd_t b);
    int_bcd_t a;
    a = b;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (b[i] >= 4'd5) begin
        a[i] = b[i] + 4'd3;
      end
    end
    return a;
  endfunction

endpackage

>>> src/fixed_precision_decimal_formatter_top.sv
// Converts one non-negative double (sign bit ignored) to a "%f" style ASCII string, one
// character per output word, with last_char on the final word and range_error on every
// word of a conversion whose integer part saturated at 2^64-1. Precision above 18 is
// taken as 18. Input words are taken only while the converter is idle. With precision
// p > 0, a split state is followed by p + 1 multiply-by-ten steps for the fraction
// digits and the rounding digit, a round state, one 64-step binary-to-BCD pass of the
// shared shift-add-3 unit for the fraction digits, another for the integer digits and
// a digit-count state; at precision 0 the multiply steps and the fraction pass are
// skipped. Then one character goes out per cycle while the output does not stall.
module fixed_precision_decimal_formatter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fpdf_pkg::VALUE_W-1:0]   in_value_bits,
  input  logic [fpdf_pkg::PREC_W-1:0]    in_precision,
  input  logic                           in_alt_form,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fpdf_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_last_char,
  output logic                           out_range_error
);

  fpdf_pkg::state_t state_r, state_nxt;

  logic [fpdf_pkg::VALUE_W-1:0] bits_r, bits_nxt;
  logic [fpdf_pkg::PREC_W-1:0]  prec_r, prec_nxt;
  logic                         alt_r, alt_nxt;
  logic [fpdf_pkg::VALUE_W-1:0] ip_r, ip_nxt;
  logic [fpdf_pkg::VALUE_W-1:0] fp_r, fp_nxt;
  logic                         err_r, err_nxt;
  logic [fpdf_pkg::VALUE_W-1:0] q_r, q_nxt;
  logic                         rnd_r, rnd_nxt;
  logic [fpdf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fpdf_pkg::VALUE_W-1:0] sh_r, sh_nxt;
  fpdf_pkg::int_bcd_t           bcd_r, bcd_nxt;
  fpdf_pkg::frac_bcd_t          frac_bcd_r, frac_bcd_nxt;
  logic [fpdf_pkg::IDX_W-1:0]   idx_r, idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [fpdf_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_err_r, out_err_nxt;

  logic                         advance;
  logic                         conv_done;
  logic [fpdf_pkg::PREC_W-1:0]  prec_clamped;

  logic [fpdf_pkg::EXP_W-1:0]   ex_raw;
  logic [fpdf_pkg::EXP_W-1:0]   ex_eff;
  logic [fpdf_pkg::MANT_W:0]    mant;
  logic [fpdf_pkg::EXP_W-1:0]   rsh;
  logic [fpdf_pkg::FIXED_W-1:0] wide;
  logic [fpdf_pkg::FIXED_W-1:0] fixed;

  logic [fpdf_pkg::VALUE_W+3:0] fp_x10;
  logic [fpdf_pkg::DIGIT_W-1:0] frac_digit;
  logic [fpdf_pkg::VALUE_W-1:0] q_x10;

  logic [fpdf_pkg::VALUE_W-1:0] r_sum;
  logic                         r_carry;
  logic                         half_up;
  logic                         ip_max;

  fpdf_pkg::int_bcd_t           bcd_adj;
  logic [fpdf_pkg::BCD_W-1:0]   bcd_adj_flat;
  fpdf_pkg::int_bcd_t           bcd_step;
  logic [fpdf_pkg::IDX_W-1:0]   top_digit;

  assign in_stall        = (state_r != fpdf_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_char   = out_last_r;
  assign out_range_error = out_err_r;

  assign advance   = !out_valid_r || !out_stall;
  assign conv_done = (cnt_r == fpdf_pkg::CNT_W'(fpdf_pkg::CONV_STEPS - 1));

  assign prec_clamped = (in_precision > fpdf_pkg::PREC_W'(fpdf_pkg::MAX_PRECISION)) ?
                        fpdf_pkg::PREC_W'(fpdf_pkg::MAX_PRECISION) : in_precision;

  // split into 64.64 fixed point
  always_comb begin
    ex_raw = bits_r[fpdf_pkg::MANT_W +: fpdf_pkg::EXP_W];
    if (ex_raw == '0) begin
      ex_eff = fpdf_pkg::EXP_W'(1);
      mant   = {1'b0, bits_r[fpdf_pkg::MANT_W-1:0]};
    end else begin
      ex_eff = ex_raw;
      mant   = {1'b1, bits_r[fpdf_pkg::MANT_W-1:0]};
    end
    wide = {{(fpdf_pkg::FIXED_W - fpdf_pkg::VALUE_W - fpdf_pkg::MANT_W - 1){1'b0}},
            mant, {fpdf_pkg::VALUE_W{1'b0}}};
    rsh  = fpdf_pkg::EXP_UNIT - ex_eff;
    if (ex_eff >= fpdf_pkg::EXP_UNIT) begin
      fixed = wide << (ex_eff - fpdf_pkg::EXP_UNIT);
    end else if (rsh >= fpdf_pkg::EXP_W'(fpdf_pkg::FIXED_W)) begin
      fixed = '0;
    end else begin
      fixed = wide >> rsh[$clog2(fpdf_pkg::FIXED_W)-1:0];
    end
  end

  assign fp_x10     = ({4'b0, fp_r} << 3) + ({4'b0, fp_r} << 1);
  assign frac_digit = fp_x10[fpdf_pkg::VALUE_W +: fpdf_pkg::DIGIT_W];
  assign q_x10      = (q_r << 3) + (q_r << 1)
                    + {{(fpdf_pkg::VALUE_W - fpdf_pkg::DIGIT_W){1'b0}}, frac_digit};

  assign r_sum   = q_r + {{(fpdf_pkg::VALUE_W - 1){1'b0}}, rnd_r};
  assign r_carry = (r_sum == fpdf_pkg::pow10(prec_r));
  assign half_up = fp_r[fpdf_pkg::VALUE_W-1] && (ip_r[0] || (|fp_r[fpdf_pkg::VALUE_W-2:0]));
  assign ip_max  = &ip_r;

  assign bcd_adj      = fpdf_pkg::dabble_adjust(bcd_r);
  assign bcd_adj_flat = bcd_adj;
  assign bcd_step     = {bcd_adj_flat[fpdf_pkg::BCD_W-2:0], sh_r[fpdf_pkg::VALUE_W-1]};

  always_comb begin
    top_digit = '0;
    for (int i = 0; i < fpdf_pkg::INT_DIGITS; i++) begin
      if (bcd_r[i] != '0) begin
        top_digit = fpdf_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpdf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fpdf_pkg::ST_SPLIT;
        end
      end
      fpdf_pkg::ST_SPLIT: begin
        state_nxt = (prec_r != '0) ? fpdf_pkg::ST_FRAC : fpdf_pkg::ST_ROUND;
      end
      fpdf_pkg::ST_FRAC: begin
        if (cnt_r == fpdf_pkg::CNT_W'(prec_r)) begin
          state_nxt = fpdf_pkg::ST_ROUND;
        end
      end
      fpdf_pkg::ST_ROUND: begin
        state_nxt = (prec_r != '0) ? fpdf_pkg::ST_CONV_FRAC : fpdf_pkg::ST_CONV_INT;
      end
      fpdf_pkg::ST_CONV_FRAC: begin
        if (conv_done) begin
          state_nxt = fpdf_pkg::ST_CONV_INT;
        end
      end
      fpdf_pkg::ST_CONV_INT: begin
        if (conv_done) begin
          state_nxt = fpdf_pkg::ST_COUNT;
        end
      end
      fpdf_pkg::ST_COUNT: begin
        state_nxt = fpdf_pkg::ST_EMIT_INT;
      end
      fpdf_pkg::ST_EMIT_INT: begin
        if (advance && idx_r == '0) begin
          state_nxt = (prec_r != '0 || alt_r) ? fpdf_pkg::ST_EMIT_DOT : fpdf_pkg::ST_IDLE;
        end
      end
      fpdf_pkg::ST_EMIT_DOT: begin
        if (advance) begin
          state_nxt = (prec_r != '0) ? fpdf_pkg::ST_EMIT_FRAC : fpdf_pkg::ST_IDLE;
        end
      end
      fpdf_pkg::ST_EMIT_FRAC: begin
        if (advance && idx_r == '0) begin
          state_nxt = fpdf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bits_nxt      = bits_r;
    prec_nxt      = prec_r;
    alt_nxt       = alt_r;
    ip_nxt        = ip_r;
    fp_nxt        = fp_r;
    err_nxt       = err_r;
    q_nxt         = q_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    bcd_nxt       = bcd_r;
    frac_bcd_nxt  = frac_bcd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      fpdf_pkg::ST_IDLE: begin
        if (in_valid) begin
          bits_nxt = in_value_bits;
          prec_nxt = prec_clamped;
          alt_nxt  = in_alt_form;
        end
      end
      fpdf_pkg::ST_SPLIT: begin
        q_nxt   = '0;
        rnd_nxt = 1'b0;
        cnt_nxt = '0;
        if (ex_eff >= fpdf_pkg::EXP_SAT) begin
          ip_nxt  = '1;
          fp_nxt  = '0;
          err_nxt = 1'b1;
        end else begin
          ip_nxt  = fixed[fpdf_pkg::FIXED_W-1:fpdf_pkg::VALUE_W];
          fp_nxt  = fixed[fpdf_pkg::VALUE_W-1:0];
          err_nxt = 1'b0;
        end
      end
      fpdf_pkg::ST_FRAC: begin
        fp_nxt  = fp_x10[fpdf_pkg::VALUE_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < fpdf_pkg::CNT_W'(prec_r)) begin
          q_nxt = q_x10;
        end else begin
          rnd_nxt = (frac_digit >= 4'd5);
        end
      end
      fpdf_pkg::ST_ROUND: begin
        cnt_nxt = '0;
        bcd_nxt = '0;
        if (prec_r == '0) begin
          if (half_up) begin
            if (ip_max) begin
              err_nxt = 1'b1;
            end else begin
              ip_nxt = ip_r + 1'b1;
            end
          end
          sh_nxt = (half_up && !ip_max) ? ip_r + 1'b1 : ip_r;
        end else begin
          if (r_carry) begin
            if (ip_max) begin
              err_nxt = 1'b1;
            end else begin
              ip_nxt = ip_r + 1'b1;
            end
          end
          sh_nxt = r_carry ? '0 : r_sum;
        end
      end
      fpdf_pkg::ST_CONV_FRAC: begin
        cnt_nxt = cnt_r + 1'b1;
        bcd_nxt = bcd_step;
        sh_nxt  = sh_r << 1;
        if (conv_done) begin
          frac_bcd_nxt = bcd_step[fpdf_pkg::MAX_PRECISION-1:0];
          bcd_nxt      = '0;
          sh_nxt       = ip_r;
        end
      end
      fpdf_pkg::ST_CONV_INT: begin
        cnt_nxt = cnt_r + 1'b1;
        bcd_nxt = bcd_step;
        sh_nxt  = sh_r << 1;
      end
      fpdf_pkg::ST_COUNT: begin
        idx_nxt = top_digit;
      end
      fpdf_pkg::ST_EMIT_INT: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = fpdf_pkg::CHAR_ZERO + {4'b0, bcd_r[idx_r]};
          out_last_nxt  = (idx_r == '0) && (prec_r == '0) && !alt_r;
          out_err_nxt   = err_r;
          idx_nxt       = idx_r - 1'b1;
        end
      end
      fpdf_pkg::ST_EMIT_DOT: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = fpdf_pkg::CHAR_POINT;
          out_last_nxt  = (prec_r == '0);
          out_err_nxt   = err_r;
          idx_nxt       = fpdf_pkg::IDX_W'(prec_r - 1'b1);
        end
      end
      fpdf_pkg::ST_EMIT_FRAC: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = fpdf_pkg::CHAR_ZERO
                        + {4'b0, frac_bcd_r[idx_r[fpdf_pkg::FIDX_W-1:0]]};
          out_last_nxt  = (idx_r == '0);
          out_err_nxt   = err_r;
          idx_nxt       = idx_r - 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpdf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    prec_r     <= prec_nxt;
    alt_r      <= alt_nxt;
    ip_r       <= ip_nxt;
    fp_r       <= fp_nxt;
    err_r      <= err_nxt;
    q_r        <= q_nxt;
    rnd_r      <= rnd_nxt;
    cnt_r      <= cnt_nxt;
    sh_r       <= sh_nxt;
    bcd_r      <= bcd_nxt;
    frac_bcd_r <= frac_bcd_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

`ifndef SYNTHESIS
  a_accept_starts_split: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == fpdf_pkg::ST_SPLIT))
    else $error("accepted word did not start a conversion");

  a_frac_below_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpdf_pkg::ST_ROUND && prec_r != '0) |-> (q_r < fpdf_pkg::pow10(prec_r)))
    else $error("scaled fraction out of range");

  a_saturated_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpdf_pkg::ST_EMIT_FRAC && err_r)
      |-> (frac_bcd_r[idx_r[fpdf_pkg::FIDX_W-1:0]] == '0))
    else $error("non-zero fraction digit on saturated conversion");

  a_point_needed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpdf_pkg::ST_EMIT_DOT) |-> (prec_r != '0 || alt_r))
    else $error("point emitted without precision or alternate form");
`endif

endmodule
